[design/mbd_pkg.sv]
package mbd_pkg;

    // Field widths fixed by the stream format.
    localparam int CH_W      = 8;
    localparam int NCH       = 4;
    localparam int PIX_W     = CH_W * NCH;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Result queue between the accumulator and the master side.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_LOG2  = 2'd0,
        CFG_HEIGHT_LOG2 = 2'd1,
        CFG_MIP_LEVEL   = 2'd2,
        CFG_COLOR_MODE  = 2'd3
    } cfg_idx_t;

    // One pixel, red in the lowest byte.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pix_t;

    // Per-request control that travels with the memory access.
    typedef struct packed {
        logic first;
        logic emit;
        logic last;
        logic rgba;
    } acc_ctl_t;

    // One finished output pixel.
    typedef struct packed {
        logic last;
        pix_t avg;
    } res_t;

endpackage

[design/mbd_accum.sv]
module mbd_accum #(
    parameter int MAX_SIDE_LOG2 = 11,
    localparam int SH_W = $clog2(2 * MAX_SIDE_LOG2 + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     restart,
    input  logic                     req_valid,
    input  logic [MAX_SIDE_LOG2-1:0] req_idx,
    input  mbd_pkg::acc_ctl_t        req_ctl,
    input  logic [SH_W-1:0]          req_shift,
    input  mbd_pkg::pix_t            req_pix,
    output logic                     res_valid,
    output mbd_pkg::res_t            res_item
);

    localparam int DEPTH  = 1 << MAX_SIDE_LOG2;
    localparam int SUM_W  = 2 * MAX_SIDE_LOG2 + mbd_pkg::CH_W;
    localparam int WORD_W = mbd_pkg::NCH * SUM_W;

    // Column sums of all four channels share one word.
    logic [WORD_W-1:0] sum_mem [DEPTH];

    logic [WORD_W-1:0]              rd_data_reg;
    logic                           s1_valid_reg;
    logic [MAX_SIDE_LOG2-1:0]       s1_idx_reg;
    mbd_pkg::acc_ctl_t              s1_ctl_reg;
    logic [SH_W-1:0]                s1_shift_reg;
    logic [mbd_pkg::PIX_W-1:0]      s1_pix_reg;

    logic                           byp_valid_reg;
    logic [MAX_SIDE_LOG2-1:0]       byp_idx_reg;
    logic [WORD_W-1:0]              byp_data_reg;

    logic [WORD_W-1:0]              wr_data;
    logic [mbd_pkg::PIX_W-1:0]      avg_bus;

    // Read the entry as the request enters; write back the updated sum in the next cycle.
    always_ff @(posedge aclk) begin
        if (req_valid) begin
            rd_data_reg  <= sum_mem[req_idx];
            s1_idx_reg   <= req_idx;
            s1_ctl_reg   <= req_ctl;
            s1_shift_reg <= req_shift;
            s1_pix_reg   <= req_pix;
        end
        if (s1_valid_reg) begin
            sum_mem[s1_idx_reg] <= wr_data;
            byp_idx_reg         <= s1_idx_reg;
            byp_data_reg        <= wr_data;
        end
    end

    // Control state of the update stage and the forwarding register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= req_valid;
            if (restart) begin
                byp_valid_reg <= 1'b0;
            end else if (s1_valid_reg) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    // Add the pixel to the sum. The last write is forwarded because the read of the
    // following request happened on the same edge as that write. The first pixel of a
    // block starts from zero, so stale entries are never seen.
    always_comb begin
        logic [WORD_W-1:0]       base;
        logic [SUM_W-1:0]        prev;
        logic [mbd_pkg::CH_W-1:0] add;
        logic [SUM_W-1:0]        nsum;
        logic [SUM_W-1:0]        shifted;
        logic                    alpha_lane;
        base = (byp_valid_reg && (byp_idx_reg == s1_idx_reg)) ? byp_data_reg : rd_data_reg;
        wr_data = '0;
        avg_bus = '0;
        for (int c = 0; c < mbd_pkg::NCH; c++) begin
            alpha_lane = (c == mbd_pkg::NCH - 1);
            add = (alpha_lane && !s1_ctl_reg.rgba) ? '0 :
                  s1_pix_reg[c*mbd_pkg::CH_W +: mbd_pkg::CH_W];
            prev = s1_ctl_reg.first ? '0 : base[c*SUM_W +: SUM_W];
            nsum = prev + SUM_W'(add);
            shifted = nsum >> s1_shift_reg;
            wr_data[c*SUM_W +: SUM_W] = s1_ctl_reg.emit ? '0 : nsum;
            avg_bus[c*mbd_pkg::CH_W +: mbd_pkg::CH_W] =
                (alpha_lane && !s1_ctl_reg.rgba) ? '0 : shifted[mbd_pkg::CH_W-1:0];
        end
    end

    // A block closes on this request: hand out the average.
    assign res_valid     = s1_valid_reg & s1_ctl_reg.emit;
    assign res_item.avg  = mbd_pkg::pix_t'(avg_bus);
    assign res_item.last = s1_ctl_reg.last;

endmodule

[design/mipmap_box_downsample_core.sv]
// Box-filter mipmap downsampler.
// Source pixels of one image enter in raster order on the s_ channel, one request
// per pixel (tdata: red, green, blue, alpha from bit 0 up). Each output pixel on the
// m_ channel is the truncated average of a 2^level by 2^level block, the block edge
// clamped to the image side; m_tlast marks the final pixel of the level.
// The sizes, level and color mode are set through the cfg_ write port while the
// block is idle; every write restarts the image at its first pixel.
// Throughput is one pixel per cycle while s_tready is high. Each pixel does one
// read-modify-write of its column sum in a sum memory with one read and one write
// port, with the write forwarded to a following pixel of the same column. A result
// reaches m_tvalid through the update register and then the result queue.
// A four-entry result queue decouples the receiver; when it stalls long enough to
// fill the queue, s_tready drops until space frees up.
// Reset restores the default registers (level 1, RGB, 1x1 image) and empties the
// pipeline. The sum memory needs no clearing pass: the first pixel of each block
// starts its sum from zero.
module mipmap_box_downsample_core #(
    parameter int MAX_SIDE_LOG2 = 11
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [mbd_pkg::CFG_W-1:0]        cfg_wdata,
    // Source pixels.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]        s_tdata,  // red, green, blue, alpha
    // Averaged pixels.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbd_pkg::PIX_W-1:0]        m_tdata,  // avg_red, avg_green, avg_blue, avg_alpha
    output logic                             m_tlast   // last_of_image
);

    localparam int POS_W = MAX_SIDE_LOG2;
    localparam int SH_W  = $clog2(2 * MAX_SIDE_LOG2 + 1);

    logic [mbd_pkg::CFG_W-1:0] width_log2_reg;
    logic [mbd_pkg::CFG_W-1:0] height_log2_reg;
    logic [mbd_pkg::CFG_W-1:0] mip_level_reg;
    logic                      color_mode_reg;
    logic                      restart;

    logic [POS_W-1:0] column_pos_reg, column_pos_next;
    logic [POS_W-1:0] row_pos_reg, row_pos_next;

    logic [mbd_pkg::CFG_W-1:0] wl, hl, bwl, bhl;
    logic [POS_W-1:0]          wmax, hmax, bwm, bhm;
    logic [POS_W-1:0]          col, row, idx;
    logic [SH_W-1:0]           shift;
    mbd_pkg::acc_ctl_t         ctl;
    logic                      in_fire;

    logic                      res_valid;
    mbd_pkg::res_t             res_item;

    mbd_pkg::res_t                 outq_mem [mbd_pkg::OUT_DEPTH];
    logic [mbd_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mbd_pkg::OUT_CNT_W-1:0] cnt_reg;
    logic                          pop;
    mbd_pkg::res_t                 head;

    // Register writes; any listed index restarts the image.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
            mip_level_reg   <= mbd_pkg::CFG_W'(1);
            color_mode_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (mbd_pkg::cfg_idx_t'(cfg_addr))
                mbd_pkg::CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_wdata;
                mbd_pkg::CFG_HEIGHT_LOG2: height_log2_reg <= cfg_wdata;
                mbd_pkg::CFG_MIP_LEVEL:   mip_level_reg   <= cfg_wdata;
                mbd_pkg::CFG_COLOR_MODE:  color_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (mbd_pkg::cfg_idx_t'(cfg_addr))
            mbd_pkg::CFG_WIDTH_LOG2,
            mbd_pkg::CFG_HEIGHT_LOG2,
            mbd_pkg::CFG_MIP_LEVEL,
            mbd_pkg::CFG_COLOR_MODE: restart = cfg_wr_en;
            default:                 restart = 1'b0;
        endcase
    end

    // Clamp the sides, derive block sizes and the masks of each position.
    always_comb begin
        wl  = (width_log2_reg > mbd_pkg::CFG_W'(MAX_SIDE_LOG2)) ?
              mbd_pkg::CFG_W'(MAX_SIDE_LOG2) : width_log2_reg;
        hl  = (height_log2_reg > mbd_pkg::CFG_W'(MAX_SIDE_LOG2)) ?
              mbd_pkg::CFG_W'(MAX_SIDE_LOG2) : height_log2_reg;
        bwl = (mip_level_reg < wl) ? mip_level_reg : wl;
        bhl = (mip_level_reg < hl) ? mip_level_reg : hl;
        for (int i = 0; i < POS_W; i++) begin
            wmax[i] = (mbd_pkg::CFG_W'(i) < wl);
            hmax[i] = (mbd_pkg::CFG_W'(i) < hl);
            bwm[i]  = (mbd_pkg::CFG_W'(i) < bwl);
            bhm[i]  = (mbd_pkg::CFG_W'(i) < bhl);
        end
    end

    // Column sum index and block flags for the pixel at the current position.
    always_comb begin
        col       = column_pos_reg & wmax;
        row       = row_pos_reg & hmax;
        idx       = col >> bwl;
        shift     = SH_W'(bwl) + SH_W'(bhl);
        ctl.first = ((col & bwm) == '0) && ((row & bhm) == '0);
        ctl.emit  = ((col & bwm) == bwm) && ((row & bhm) == bhm);
        ctl.last  = (col == wmax) && (row == hmax);
        ctl.rgba  = color_mode_reg;
    end

    // Raster position advance, wrapping to a new image after the last pixel.
    always_comb begin
        if (col == wmax) begin
            column_pos_next = '0;
            row_pos_next    = (row == hmax) ? '0 : row + POS_W'(1);
        end else begin
            column_pos_next = col + POS_W'(1);
            row_pos_next    = row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
        end else if (in_fire) begin
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
        end
    end

    // Accept while the queue has room for the result in flight and a new one.
    assign s_tready = (cnt_reg + mbd_pkg::OUT_CNT_W'(res_valid)) <
                      mbd_pkg::OUT_CNT_W'(mbd_pkg::OUT_DEPTH);
    assign in_fire  = s_tvalid & s_tready;

    mbd_accum #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .req_valid (in_fire),
        .req_idx   (idx),
        .req_ctl   (ctl),
        .req_shift (shift),
        .req_pix   (mbd_pkg::pix_t'(s_tdata)),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            outq_mem[wr_ptr_reg] <= res_item;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + mbd_pkg::OUT_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + mbd_pkg::OUT_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + mbd_pkg::OUT_CNT_W'(res_valid) -
                       mbd_pkg::OUT_CNT_W'(pop);
        end
    end

    assign head     = outq_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid & m_tready;
    assign m_tdata  = head.avg;
    assign m_tlast  = head.last;

`ifndef SYNTH
    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= mbd_pkg::OUT_CNT_W'(mbd_pkg::OUT_DEPTH))
        else $error("result queue overfilled");

    // A result is never pushed into a full queue that is not draining.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && (cnt_reg == mbd_pkg::OUT_CNT_W'(mbd_pkg::OUT_DEPTH)) && !pop))
        else $error("result pushed into full queue");

    // A register write restarts the raster position.
    a_restart_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (column_pos_reg == '0) && (row_pos_reg == '0))
        else $error("position not cleared after register write");
`endif

endmodule

[verif/tb_mipmap_box_downsample_core.sv]
module tb_mipmap_box_downsample_core;

    localparam int SIDE_MAX       = 11;
    localparam int SUM_DEPTH      = 1 << SIDE_MAX;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_LEN       = 300;
    localparam int HOLD_PIXELS    = 400;
    localparam int RANDOM_PIXELS  = 1150;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [mbd_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [mbd_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [mbd_pkg::PIX_W-1:0]     s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [mbd_pkg::PIX_W-1:0]     m_tdata;
    logic                          m_tlast;

    mipmap_box_downsample_core #(
        .MAX_SIDE_LOG2(SIDE_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Pending source pixels and the block averages they should produce.
    mbd_pkg::pix_t pixel_q[$];
    mbd_pkg::res_t avg_expect_q[$];

    // Shadow copy of the registers and the column sums.
    bit [3:0]    cur_wl   = 4'd0;
    bit [3:0]    cur_hl   = 4'd0;
    bit [3:0]    cur_lvl  = 4'd1;
    bit          cur_rgba = 1'b0;
    bit [29:0]   col_sum[SUM_DEPTH][4];
    int unsigned next_col = 0;
    int unsigned next_row = 0;

    idle_mode_e idle_mode   = IDLE_NONE;
    logic       hold_armed  = 1'b0;
    int         hold_count  = 0;
    int         errors      = 0;
    int         pixels_in   = 0;
    int         results_out = 0;
    int         in_stalls   = 0;
    int         phases      = 0;
    string      avg_names[4] = '{"avg_red", "avg_green", "avg_blue", "avg_alpha"};

    wire rx_hold = hold_armed && (hold_count < HOLD_LEN);

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung block.
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("DONE: errors detected");
        $finish;
    end

    // Long receiver hold-off, counted on its own once armed.
    always @(posedge aclk) begin
        if (hold_armed && hold_count < HOLD_LEN) begin
            hold_count <= hold_count + 1;
        end
    end

    function automatic bit sender_pause(input idle_mode_e mode);
        case (mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 75;
            IDLE_BOTH:   return $urandom_range(0, 99) < 13;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pause(input idle_mode_e mode);
        case (mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 75;
            IDLE_BOTH:     return $urandom_range(0, 99) < 13;
            default:       return 1'b0;
        endcase
    endfunction

    // Bytes lean toward the extremes now and then.
    function automatic bit [7:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic mbd_pkg::pix_t random_pixel();
        mbd_pkg::pix_t px;
        px.red   = random_byte();
        px.green = random_byte();
        px.blue  = random_byte();
        px.alpha = random_byte();
        return px;
    endfunction

    task automatic flag_error(input string msg);
        begin
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        end
    endtask

    // Any register write starts a new image with empty sums.
    task automatic restart_image();
        begin
            for (int i = 0; i < SUM_DEPTH; i++) begin
                for (int c = 0; c < 4; c++) begin
                    col_sum[i][c] = '0;
                end
            end
            next_col = 0;
            next_row = 0;
        end
    endtask

    // Add one source pixel to its column sum; close the block when its
    // bottom-right pixel arrives.
    task automatic accumulate_pixel(input mbd_pkg::pix_t px);
        int unsigned   wl, hl, bwl, bhl, wmax, hmax, bwm, bhm, col, row, idx, sh;
        bit [7:0]      chan[4];
        bit [29:0]     quot;
        mbd_pkg::res_t res;
        begin
            wl   = (cur_wl > SIDE_MAX) ? SIDE_MAX : cur_wl;
            hl   = (cur_hl > SIDE_MAX) ? SIDE_MAX : cur_hl;
            bwl  = (cur_lvl < wl) ? cur_lvl : wl;
            bhl  = (cur_lvl < hl) ? cur_lvl : hl;
            wmax = (1 << wl) - 1;
            hmax = (1 << hl) - 1;
            bwm  = (1 << bwl) - 1;
            bhm  = (1 << bhl) - 1;
            col  = next_col & wmax;
            row  = next_row & hmax;
            idx  = (col >> bwl) & (SUM_DEPTH - 1);
            chan[0] = px.red;
            chan[1] = px.green;
            chan[2] = px.blue;
            chan[3] = px.alpha;
            for (int c = 0; c < 4; c++) begin
                if (c < 3 || cur_rgba) begin
                    col_sum[idx][c] = col_sum[idx][c] + chan[c];
                end
            end
            if ((col & bwm) == bwm && (row & bhm) == bhm) begin
                sh = bwl + bhl;
                for (int c = 0; c < 4; c++) begin
                    quot = col_sum[idx][c] >> sh;
                    res.avg[8*c +: 8] = (c < 3 || cur_rgba) ? quot[7:0] : 8'h00;
                    col_sum[idx][c] = '0;
                end
                res.last = (col == wmax) && (row == hmax);
                avg_expect_q.push_back(res);
            end
            if (col == wmax) begin
                next_col = 0;
                next_row = (row == hmax) ? 0 : row + 1;
            end else begin
                next_col = col + 1;
                next_row = row;
            end
        end
    endtask

    task automatic check_result(input mbd_pkg::pix_t got, input logic got_last);
        mbd_pkg::res_t want;
        begin
            results_out++;
            if (avg_expect_q.size() == 0) begin
                flag_error($sformatf("unexpected result %08h last %b", got, got_last));
            end else begin
                want = avg_expect_q.pop_front();
                for (int c = 0; c < 4; c++) begin
                    if (got[8*c +: 8] !== want.avg[8*c +: 8]) begin
                        flag_error($sformatf("result %0d: %s expected %02h, got %02h",
                                             results_out, avg_names[c],
                                             want.avg[8*c +: 8], got[8*c +: 8]));
                    end
                end
                if (got_last !== want.last) begin
                    flag_error($sformatf("result %0d: last_of_image expected %b, got %b",
                                         results_out, want.last, got_last));
                end
            end
        end
    endtask

    // Source side: predict each accepted request, then offer the next pixel.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_pixel(mbd_pkg::pix_t'(s_tdata));
                pixels_in++;
            end
            if (s_tvalid && !s_tready) begin
                in_stalls++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && !sender_pause(idle_mode)) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each accepted request and pick the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(mbd_pkg::pix_t'(m_tdata), m_tlast);
            end
            m_tready <= !rx_hold && !receiver_pause(idle_mode);
        end
    end

    // Wait until every pixel is accepted and every average has arrived,
    // then let the pipeline empty of pixels that close no block.
    task automatic wait_drained();
        begin
            @(negedge aclk);
            while (pixel_q.size() != 0 || s_tvalid || avg_expect_q.size() != 0) begin
                @(negedge aclk);
            end
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input mbd_pkg::cfg_idx_t idx, input bit [3:0] val);
        begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            case (idx)
                mbd_pkg::CFG_WIDTH_LOG2:  cur_wl   = val;
                mbd_pkg::CFG_HEIGHT_LOG2: cur_hl   = val;
                mbd_pkg::CFG_MIP_LEVEL:   cur_lvl  = val;
                mbd_pkg::CFG_COLOR_MODE:  cur_rgba = val[0];
                default: ;
            endcase
            restart_image();
        end
    endtask

    // Write the registers that change, plus some that do not; at least one
    // write always happens so the image restarts.
    task automatic apply_settings(input bit [3:0] wl, input bit [3:0] hl, input bit [3:0] lvl,
                                  input bit rgba, input bit write_all);
        bit       any;
        bit [2:0] junk;
        begin
            any  = 1'b0;
            junk = 3'($urandom_range(0, 7));
            if (write_all || wl != cur_wl || $urandom_range(0, 3) == 0) begin
                write_reg(mbd_pkg::CFG_WIDTH_LOG2, wl);
                any = 1'b1;
            end
            if (write_all || hl != cur_hl || $urandom_range(0, 3) == 0) begin
                write_reg(mbd_pkg::CFG_HEIGHT_LOG2, hl);
                any = 1'b1;
            end
            if (write_all || lvl != cur_lvl || $urandom_range(0, 3) == 0) begin
                write_reg(mbd_pkg::CFG_MIP_LEVEL, lvl);
                any = 1'b1;
            end
            // The color mode only looks at bit 0; the upper bits are noise.
            if (write_all || rgba != cur_rgba || $urandom_range(0, 3) == 0) begin
                write_reg(mbd_pkg::CFG_COLOR_MODE, {junk, rgba});
                any = 1'b1;
            end
            if (!any) begin
                write_reg(mbd_pkg::CFG_MIP_LEVEL, lvl);
            end
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            phases++;
        end
    endtask

    task automatic run_phase(input bit [3:0] wl, input bit [3:0] hl, input bit [3:0] lvl,
                             input bit rgba, input int npix, input idle_mode_e mode);
        begin
            apply_settings(wl, hl, lvl, rgba, 1'b0);
            idle_mode = mode;
            for (int i = 0; i < npix; i++) begin
                pixel_q.push_back(random_pixel());
            end
            wait_drained();
        end
    endtask

    // Stimulus sequence.
    initial begin
        int            wl, hl, lvl, rgba, npix, area, random_pixels, phase_no;
        mbd_pkg::pix_t px;
        random_pixels = 0;
        phase_no      = 0;
        restart_image();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: a 1x1 image, so every pixel is its own last result.
        idle_mode = IDLE_NONE;
        pixel_q.push_back(mbd_pkg::pix_t'(32'hFFFF_FFFF));
        pixel_q.push_back(mbd_pkg::pix_t'(32'h0000_0000));
        pixel_q.push_back(random_pixel());
        wait_drained();

        // Level beyond both sides in RGBA, all channels at maximum, two images.
        apply_settings(4'd1, 4'd1, 4'd15, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++) begin
            pixel_q.push_back(mbd_pkg::pix_t'(32'hFFFF_FFFF));
        end
        wait_drained();

        // RGB mode with alpha at maximum, which must read back as zero.
        apply_settings(4'd2, 4'd1, 4'd1, 1'b0, 1'b0);
        idle_mode = IDLE_BOTH;
        pixel_q.push_back(mbd_pkg::pix_t'(32'hFF00_0000));
        for (int i = 1; i < 8; i++) begin
            px       = random_pixel();
            px.alpha = 8'hFF;
            pixel_q.push_back(px);
        end
        wait_drained();

        // Part of an image, cut short by the next register write.
        apply_settings(4'd2, 4'd2, 4'd2, 1'b1, 1'b0);
        idle_mode = IDLE_SENDER;
        for (int i = 0; i < 5; i++) begin
            pixel_q.push_back(random_pixel());
        end
        wait_drained();

        // Oversized width, the start of a 2048-pixel row, with the receiver held
        // off long enough to fill the result queue and stall the input.
        apply_settings(4'd15, 4'd0, 4'd3, 1'b1, 1'b0);
        idle_mode = IDLE_NONE;
        @(posedge aclk);
        hold_armed <= 1'b1;
        for (int i = 0; i < HOLD_PIXELS; i++) begin
            pixel_q.push_back(random_pixel());
        end
        wait_drained();

        // Oversized height, first part of the image only.
        run_phase(4'd0, 4'd15, 4'd2, 1'b0, 200, IDLE_RECEIVER);

        // Random settings, mostly whole images with random content.
        while (random_pixels < RANDOM_PIXELS) begin
            lvl  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            rgba = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) begin
                // A clamped side, so only a short stretch of the image.
                if ($urandom_range(0, 1) == 0) begin
                    wl = $urandom_range(12, 15);
                    hl = $urandom_range(0, 2);
                end else begin
                    wl = $urandom_range(0, 2);
                    hl = $urandom_range(12, 15);
                end
                npix = $urandom_range(20, 100);
            end else begin
                wl   = $urandom_range(0, 6);
                hl   = $urandom_range(0, (8 - wl > 6) ? 6 : 8 - wl);
                area = 1 << (wl + hl);
                if (area > 1 && $urandom_range(0, 99) < 15) begin
                    npix = $urandom_range(1, area - 1);
                end else begin
                    npix = area * $urandom_range(1, 3);
                end
            end
            run_phase(4'(wl), 4'(hl), 4'(lvl), 1'(rgba), npix, idle_mode_e'(phase_no % 4));
            random_pixels += npix;
            phase_no++;
        end

        $display("Ran %0d register settings: %0d source pixels in, %0d averages checked.",
                 phases, pixels_in, results_out);
        $display("The input was back-pressured for %0d cycles.", in_stalls);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
